// ===== src/tct_pkg.sv =====
package tct_pkg;

  localparam int IDX_W = 16;
  localparam int VAL_W = 32;
  localparam int MAG_W = VAL_W - 1;
  localparam int PROD_W = 2 * VAL_W;

  // Field codes used to select a coordinate of a stored corner.
  localparam logic [2:0] FLD_X = 3'd0;
  localparam logic [2:0] FLD_Y = 3'd1;
  localparam logic [2:0] FLD_Z = 3'd2;
  localparam logic [2:0] FLD_U = 3'd3;
  localparam logic [2:0] FLD_V = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
    logic signed [VAL_W-1:0] u;
    logic signed [VAL_W-1:0] v;
  } corner_t;

  // A saturated difference split into sign and magnitude.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } smag_t;

  function automatic logic signed [VAL_W-1:0] field_of(corner_t c, logic [2:0] f);
    logic signed [VAL_W-1:0] r;
    unique case (f)
      FLD_X:   r = c.x;
      FLD_Y:   r = c.y;
      FLD_Z:   r = c.z;
      FLD_U:   r = c.u;
      FLD_V:   r = c.v;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Difference p - q, clamped to the symmetric range, as sign and magnitude.
  function automatic smag_t sat_diff(logic signed [VAL_W-1:0] p,
                                     logic signed [VAL_W-1:0] q);
    logic signed [VAL_W:0] d;
    smag_t r;
    d = VAL_W'(1) == 1 ? ($signed({p[VAL_W-1], p}) - $signed({q[VAL_W-1], q})) : '0;
    r.neg = d[VAL_W];
    if (d[VAL_W]) begin
      // The most negative 32-bit value lies outside the symmetric range as well.
      if (!d[VAL_W-1] || d[MAG_W-1:0] == '0) r.mag = {MAG_W{1'b1}};
      else r.mag = MAG_W'(-d);
    end else begin
      if (d[VAL_W-1]) r.mag = {MAG_W{1'b1}};
      else r.mag = d[MAG_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/tct_in_if.sv =====
interface tct_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] vert_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] tex_u;
  logic [31:0] tex_v;
  logic        final_corner;

  modport source (output valid, vert_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  final_corner, input ready);
  modport sink (input valid, vert_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                final_corner, output ready);
endinterface

// ===== src/tct_out_if.sv =====
interface tct_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_index;
  logic [31:0] tan_x;
  logic [31:0] tan_y;
  logic [31:0] tan_z;
  logic        degenerate;
  logic        last_of_triangle;
  logic        mesh_done;

  modport source (output valid, out_index, tan_x, tan_y, tan_z, degenerate,
                  last_of_triangle, mesh_done, input ready);
  modport sink (input valid, out_index, tan_x, tan_y, tan_z, degenerate,
                last_of_triangle, mesh_done, output ready);
endinterface

// ===== src/triangle_corner_tangents_core.sv =====
// Channel   Dir  Beat contents
// in_ch     in   one triangle corner: index, position, texture coordinate, final mark
// out_ch    out  one corner tangent: index, tangent, degenerate, last, mesh done
//
// The first two corners of a triangle are only stored; the third starts the sequencer.
// Each corner needs 2 multiplies and, unless degenerate, 2 multiplies and a division per axis,
// on a shift-add unit and a restoring divider. Input is held off meanwhile.
// Reset is synchronous and clears the corner count and the sequencer.
// A stalled result beat holds the sequencer at the next corner's result until it is taken.
module triangle_corner_tangents_core #(
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  tct_in_if.sink    in_ch,
  tct_out_if.source out_ch
);
  import tct_pkg::*;

  localparam int DW = PROD_W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DFIN = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state_r;
  logic [1:0] count_r;
  logic [1:0] crn_r;
  logic [2:0] step_r;
  logic [CW-1:0] cnt_r;
  logic final_r;

  corner_t c0_r, c1_r, c2_r;

  logic [MAG_W-1:0]   mcand_r;
  logic [2*MAG_W-1:0] p_r;
  logic               pneg_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] det_r;

  logic [DW-1:0]     dvd_r;
  logic [PROD_W-1:0] rem_r;
  logic [PROD_W-1:0] ud_r;
  logic [VAL_W-1:0]  q_r;
  logic              ovf_r;
  logic              dneg_r;

  logic [VAL_W-1:0] tan_r [3];
  logic             degen_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [VAL_W-1:0] out_tx_r, out_ty_r, out_tz_r;
  logic             out_deg_r, out_last_r, out_done_r;

  // Corner roles: base, first other, second other.
  corner_t ca, cb, cd;
  always_comb begin
    unique case (crn_r)
      2'd0: begin ca = c0_r; cb = c1_r; cd = c2_r; end
      2'd1: begin ca = c1_r; cb = c0_r; cd = c2_r; end
      default: begin ca = c2_r; cb = c1_r; cd = c0_r; end
    endcase
  end

  // Operand selection for the current multiply.
  logic [1:0] ax;
  logic [2:0] fld_ax;
  smag_t opa, opb;
  assign ax = 2'((step_r - 3'd2) >> 1);
  assign fld_ax = {1'b0, ax};
  always_comb begin
    unique case (step_r)
      3'd0: begin
        opa = sat_diff(field_of(cb, FLD_U), field_of(ca, FLD_U));
        opb = sat_diff(field_of(cd, FLD_V), field_of(ca, FLD_V));
      end
      3'd1: begin
        opa = sat_diff(field_of(cd, FLD_U), field_of(ca, FLD_U));
        opb = sat_diff(field_of(cb, FLD_V), field_of(ca, FLD_V));
      end
      3'd2, 3'd4, 3'd6: begin
        opa = sat_diff(field_of(cd, FLD_V), field_of(ca, FLD_V));
        opb = sat_diff(field_of(cb, fld_ax), field_of(ca, fld_ax));
      end
      default: begin
        opa = sat_diff(field_of(cb, FLD_V), field_of(ca, FLD_V));
        opb = sat_diff(field_of(cd, fld_ax), field_of(ca, fld_ax));
      end
    endcase
  end

  logic [MAG_W:0] msum;
  assign msum = {1'b0, p_r[2*MAG_W-1:MAG_W]} + (p_r[0] ? {1'b0, mcand_r} : '0);

  logic signed [PROD_W-1:0] prod_s, comb_val;
  assign prod_s = pneg_r ? -$signed(PROD_W'(p_r)) : $signed(PROD_W'(p_r));
  assign comb_val = acc_r - prod_s;

  logic [PROD_W-1:0] rem_sh;
  logic              rem_ge;
  assign rem_sh = {rem_r[PROD_W-2:0], dvd_r[DW-1]};
  assign rem_ge = rem_sh >= ud_r;

  logic [VAL_W-1:0] div_res;
  always_comb begin
    if (dneg_r) begin
      if (ovf_r || q_r > {1'b1, {(VAL_W-1){1'b0}}}) div_res = {1'b1, {(VAL_W-1){1'b0}}};
      else div_res = -q_r;
    end else begin
      if (ovf_r || q_r[VAL_W-1]) div_res = {1'b0, {(VAL_W-1){1'b1}}};
      else div_res = q_r;
    end
  end

  logic in_acc;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;

  logic emit_go;
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  corner_t in_c;
  assign in_c = '{idx: in_ch.vert_index, x: in_ch.pos_x, y: in_ch.pos_y,
                  z: in_ch.pos_z, u: in_ch.tex_u, v: in_ch.tex_v};

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (count_r == 2'd0) c0_r <= in_c;
      else if (count_r == 2'd1) c1_r <= in_c;
      else begin
        c2_r <= in_c;
        final_r <= in_ch.final_corner;
      end
    end
    unique case (state_r)
      S_LOAD: begin
        mcand_r <= opa.mag;
        p_r <= {{MAG_W{1'b0}}, opb.mag};
        pneg_r <= opa.neg ^ opb.neg;
      end
      S_MUL: p_r <= {msum, p_r[MAG_W-1:1]};
      S_ACC: begin
        if (!step_r[0]) acc_r <= prod_s;
        else if (step_r == 3'd1) begin
          det_r <= comb_val;
          degen_r <= (comb_val == '0);
          if (comb_val == '0) begin
            tan_r[0] <= '0;
            tan_r[1] <= '0;
            tan_r[2] <= '0;
          end
        end else begin
          dneg_r <= comb_val[PROD_W-1] ^ det_r[PROD_W-1];
          dvd_r <= {(comb_val[PROD_W-1] ? PROD_W'(-comb_val) : PROD_W'(comb_val)),
                    {FRAC_BITS{1'b0}}};
          ud_r <= det_r[PROD_W-1] ? PROD_W'(-det_r) : PROD_W'(det_r);
          rem_r <= '0;
          q_r <= '0;
          ovf_r <= 1'b0;
        end
      end
      S_DIV: begin
        rem_r <= rem_ge ? rem_sh - ud_r : rem_sh;
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
        ovf_r <= ovf_r | q_r[VAL_W-1];
        q_r <= {q_r[VAL_W-2:0], rem_ge};
      end
      S_DFIN: tan_r[ax] <= div_res;
      default: ;
    endcase
    if (emit_go) begin
      out_idx_r <= ca.idx;
      out_tx_r <= tan_r[0];
      out_ty_r <= tan_r[1];
      out_tz_r <= tan_r[2];
      out_deg_r <= degen_r;
      out_last_r <= (crn_r == 2'd2);
      out_done_r <= (crn_r == 2'd2) && final_r;
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= 2'd0;
      crn_r <= 2'd0;
      step_r <= 3'd0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (count_r == 2'd2) begin
              count_r <= 2'd0;
              crn_r <= 2'd0;
              step_r <= 3'd0;
              state_r <= S_LOAD;
            end else begin
              count_r <= in_ch.final_corner ? 2'd0 : count_r + 2'd1;
            end
          end
        end
        S_LOAD: begin
          cnt_r <= CW'(MAG_W);
          state_r <= S_MUL;
        end
        S_MUL: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) state_r <= S_ACC;
        end
        S_ACC: begin
          if (!step_r[0]) begin
            step_r <= step_r + 3'd1;
            state_r <= S_LOAD;
          end else if (step_r == 3'd1) begin
            if (comb_val == '0) state_r <= S_EMIT;
            else begin
              step_r <= 3'd2;
              state_r <= S_LOAD;
            end
          end else begin
            cnt_r <= CW'(DW);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) state_r <= S_DFIN;
        end
        S_DFIN: begin
          if (step_r == 3'd7) state_r <= S_EMIT;
          else begin
            step_r <= step_r + 3'd1;
            state_r <= S_LOAD;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            step_r <= 3'd0;
            if (crn_r == 2'd2) state_r <= S_IDLE;
            else begin
              crn_r <= crn_r + 2'd1;
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_index = out_idx_r;
  assign out_ch.tan_x = out_tx_r;
  assign out_ch.tan_y = out_ty_r;
  assign out_ch.tan_z = out_tz_r;
  assign out_ch.degenerate = out_deg_r;
  assign out_ch.last_of_triangle = out_last_r;
  assign out_ch.mesh_done = out_done_r;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("corner count out of range");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> count_r == 2'd0) else $error("corners held while busy");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_deg_r |-> out_tx_r == '0 && out_ty_r == '0 && out_tz_r == '0)
    else $error("degenerate result with non-zero tangent");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r) else $error("mesh done off the third result");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;
  import tct_pkg::*;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD = 4000;
  localparam longint DELTA_MAX = 64'sd2147483647;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] x, y, z, u, v;
    logic                    fin;
    logic                    drain_first;
  } corner_beat_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] tx, ty, tz;
    logic             degen, last, done;
  } tangent_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tct_in_if  in_ch();
  tct_out_if out_ch();

  triangle_corner_tangents_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  corner_beat_t pending_corners[$];
  tangent_t     expected_tangents[$];
  corner_beat_t held[2];
  int unsigned  held_count;
  int unsigned  errors;
  int unsigned  cycles;
  int unsigned  results_seen;
  logic         in_taken, out_taken;
  logic         calm_send, calm_recv;
  int unsigned  send_gap, recv_stall;
  bit           long_hold_done;

  task automatic queue_corner(corner_beat_t c);
    pending_corners.insert(pending_corners.size(), c);
  endtask

  task automatic queue_tangent(tangent_t t);
    expected_tangents.insert(expected_tangents.size(), t);
  endtask

  function automatic longint clamp_delta(logic signed [VAL_W-1:0] p,
                                         logic signed [VAL_W-1:0] q);
    longint d;
    d = longint'(p) - longint'(q);
    if (d > DELTA_MAX) d = DELTA_MAX;
    if (d < -DELTA_MAX) d = -DELTA_MAX;
    return d;
  endfunction

  function automatic logic [VAL_W-1:0] fixed_quotient(longint num, longint den);
    logic signed [127:0] n, q;
    n = num;
    n = n <<< FRAC;
    q = n / $signed(128'(den));
    if (q > 128'sd2147483647) return 32'h7fffffff;
    if (q < -128'sd2147483648) return 32'h80000000;
    return q[VAL_W-1:0];
  endfunction

  // Tangent at corner a, with b as the first and d as the second other corner.
  function automatic tangent_t corner_tangent(corner_beat_t a, corner_beat_t b,
                                              corner_beat_t d);
    tangent_t t;
    longint du1, dv1, du2, dv2, det;
    du1 = clamp_delta(b.u, a.u);
    dv1 = clamp_delta(b.v, a.v);
    du2 = clamp_delta(d.u, a.u);
    dv2 = clamp_delta(d.v, a.v);
    det = du1 * dv2 - du2 * dv1;
    t.idx = a.idx;
    t.last = 1'b0;
    t.done = 1'b0;
    t.degen = (det == 0);
    if (det == 0) begin
      t.tx = '0; t.ty = '0; t.tz = '0;
    end else begin
      t.tx = fixed_quotient(dv2 * clamp_delta(b.x, a.x) - dv1 * clamp_delta(d.x, a.x), det);
      t.ty = fixed_quotient(dv2 * clamp_delta(b.y, a.y) - dv1 * clamp_delta(d.y, a.y), det);
      t.tz = fixed_quotient(dv2 * clamp_delta(b.z, a.z) - dv1 * clamp_delta(d.z, a.z), det);
    end
    return t;
  endfunction

  task automatic predict_corner(corner_beat_t c);
    tangent_t t;
    if (held_count < 2) begin
      held[held_count] = c;
      held_count = c.fin ? 0 : held_count + 1;
    end else begin
      queue_tangent(corner_tangent(held[0], held[1], c));
      queue_tangent(corner_tangent(held[1], held[0], c));
      t = corner_tangent(c, held[1], held[0]);
      t.last = 1'b1;
      t.done = c.fin;
      queue_tangent(t);
      held_count = 0;
    end
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h7fffffff : 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h00000000 : 32'hffffffff;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic corner_beat_t make_corner(logic [IDX_W-1:0] idx,
                                               logic [VAL_W-1:0] x, logic [VAL_W-1:0] y,
                                               logic [VAL_W-1:0] z, logic [VAL_W-1:0] u,
                                               logic [VAL_W-1:0] v, logic fin);
    corner_beat_t c;
    c.idx = idx; c.x = x; c.y = y; c.z = z; c.u = u; c.v = v;
    c.fin = fin;
    c.drain_first = 1'b0;
    return c;
  endfunction

  function automatic corner_beat_t random_corner(logic fin);
    return make_corner(16'($urandom()), random_value(), random_value(), random_value(),
                       random_value(), random_value(), fin);
  endfunction

  // Acceptance is sampled at the rising edge; the predictor runs on the input beat.
  always @(posedge clk) begin
    corner_beat_t c;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c = make_corner(in_ch.vert_index, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                      in_ch.tex_u, in_ch.tex_v, in_ch.final_corner);
      predict_corner(c);
    end
  end

  always @(posedge clk) begin
    tangent_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_tangents.size() == 0) begin
        $error("unexpected result beat, index %0h", out_ch.out_index);
        errors = errors + 1;
      end else begin
        e = expected_tangents.pop_front();
        if (out_ch.out_index !== e.idx) begin
          $error("out_index: expected %0h, got %0h", e.idx, out_ch.out_index);
          errors = errors + 1;
        end
        if (out_ch.tan_x !== e.tx) begin
          $error("tan_x: expected %0h, got %0h", e.tx, out_ch.tan_x);
          errors = errors + 1;
        end
        if (out_ch.tan_y !== e.ty) begin
          $error("tan_y: expected %0h, got %0h", e.ty, out_ch.tan_y);
          errors = errors + 1;
        end
        if (out_ch.tan_z !== e.tz) begin
          $error("tan_z: expected %0h, got %0h", e.tz, out_ch.tan_z);
          errors = errors + 1;
        end
        if (out_ch.degenerate !== e.degen) begin
          $error("degenerate: expected %0b, got %0b", e.degen, out_ch.degenerate);
          errors = errors + 1;
        end
        if (out_ch.last_of_triangle !== e.last) begin
          $error("last_of_triangle: expected %0b, got %0b", e.last, out_ch.last_of_triangle);
          errors = errors + 1;
        end
        if (out_ch.mesh_done !== e.done) begin
          $error("mesh_done: expected %0b, got %0b", e.done, out_ch.mesh_done);
          errors = errors + 1;
        end
      end
    end
  end

  // Sender: one nonblocking write per signal per falling edge.
  always @(negedge clk) begin
    corner_beat_t c;
    logic busy, next_valid;
    busy = in_ch.valid && !in_taken;
    next_valid = busy;
    if (rst_n && !busy) begin
      if (in_taken) send_gap = calm_send ? 0 : $urandom_range(0, 14);
      if (send_gap > 0) begin
        send_gap--;
        next_valid = 1'b0;
      end else if (pending_corners.size() > 0 &&
                   !(pending_corners[0].drain_first && expected_tangents.size() > 0)) begin
        c = pending_corners.pop_front();
        in_ch.vert_index <= c.idx;
        in_ch.pos_x <= c.x;
        in_ch.pos_y <= c.y;
        in_ch.pos_z <= c.z;
        in_ch.tex_u <= c.u;
        in_ch.tex_v <= c.v;
        in_ch.final_corner <= c.fin;
        next_valid = 1'b1;
      end else begin
        next_valid = 1'b0;
      end
    end
    in_ch.valid <= next_valid;
  end

  // Receiver: a random stall per beat, and once a long hold-off to back up the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_taken) begin
        if (!long_hold_done && results_seen >= 30) begin
          recv_stall = LONG_HOLD;
          long_hold_done = 1'b1;
        end else begin
          recv_stall = calm_recv ? 0 : $urandom_range(0, 14);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    corner_beat_t c;
    int unsigned queued;
    in_ch.valid = 1'b0;
    in_ch.vert_index = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.tex_u = '0;
    in_ch.tex_v = '0;
    in_ch.final_corner = 1'b0;
    out_ch.ready = 1'b0;
    held_count = 0;
    errors = 0;
    cycles = 0;
    results_seen = 0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    long_hold_done = 1'b0;
    calm_send = 1'b0;
    calm_recv = 1'b0;

    // Directed: extreme triangle with saturating deltas and quotients.
    queue_corner(make_corner(16'h0000, 32'h7fffffff, 32'h80000000, 32'h0,
                             32'h80000000, 32'h7fffffff, 1'b0));
    queue_corner(make_corner(16'hffff, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                             32'h7fffffff, 32'h80000000, 1'b0));
    queue_corner(make_corner(16'h8000, 32'h0, 32'h0, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 1'b0));
    // Tiny determinant gives huge tangents.
    queue_corner(make_corner(16'h0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    queue_corner(make_corner(16'h0002, 32'h7fffffff, 32'h80000000, 32'h40000000,
                             32'h1, 32'h0, 1'b0));
    queue_corner(make_corner(16'h0003, 32'h80000000, 32'h7fffffff, 32'h1,
                             32'h0, 32'h1, 1'b0));
    // Degenerate: every corner shares one texture coordinate.
    queue_corner(make_corner(16'h0010, 32'h10000, 32'h0, 32'h0,
                             32'h5000, 32'h5000, 1'b0));
    queue_corner(make_corner(16'h0011, 32'h0, 32'h10000, 32'h0,
                             32'h5000, 32'h5000, 1'b0));
    queue_corner(make_corner(16'h0012, 32'h0, 32'h0, 32'h10000,
                             32'h5000, 32'h5000, 1'b0));
    // A final mark on a first corner, then on a second corner, discards the triangle.
    queue_corner(random_corner(1'b1));
    queue_corner(random_corner(1'b0));
    queue_corner(random_corner(1'b1));
    // Ordinary triangle closing the mesh.
    queue_corner(make_corner(16'h0020, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    queue_corner(make_corner(16'h0021, 32'h10000, 32'h0, 32'h0,
                             32'h10000, 32'h0, 1'b0));
    queue_corner(make_corner(16'h0022, 32'h0, 32'h10000, 32'h0,
                             32'h0, 32'h10000, 1'b1));
    // The sender waits for the pipeline to drain before the next triangle.
    c = random_corner(1'b0);
    c.drain_first = 1'b1;
    queue_corner(c);
    queue_corner(random_corner(1'b0));
    queue_corner(random_corner(1'b0));

    // Random part: mostly whole triangles, some broken off by an early final mark.
    queued = 0;
    while (queued < 335) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_corner(random_corner(1'b0));
        if ($urandom_range(0, 1)) begin
          queue_corner(random_corner(1'b0));
          queued++;
        end
        queue_corner(random_corner(1'b1));
        queued += 2;
      end else begin
        queue_corner(random_corner(1'b0));
        queue_corner(random_corner(1'b0));
        queue_corner(random_corner($urandom_range(0, 5) == 0));
        queued += 3;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_corners.size() > 0 || (in_ch.valid && !in_taken)) begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) begin
        calm_send = ~calm_send;
        calm_recv = $urandom_range(0, 1);
      end
    end
    while (expected_tangents.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tct_pkg.sv
src/tct_in_if.sv
src/tct_out_if.sv
src/triangle_corner_tangents_core.sv
bench/tb.sv
